// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers, clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/sitoda_pkg.sv -----
package sitoda_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIG_IDX_W  = 4;
    localparam int CNT_W      = 5;
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
    localparam logic [CNT_W-1:0]  LAST_SHIFT  = 5'd31;
    localparam logic [3:0]        BCD_ADJ_LIM = 4'd5;
    localparam logic [3:0]        BCD_ADJ     = 4'd3;

    typedef logic [3:0] t_digit;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [BIN_W-1:0] mag;
    } t_bcd_cmd;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIG_IDX_W-1:0] ndig;
    } t_bcd_stat;

endpackage

// ----- rtl/core/sitoda_bcd_unit.sv -----
module sitoda_bcd_unit (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  sitoda_pkg::t_bcd_cmd                                 i_cmd,
    output sitoda_pkg::t_bcd_stat                                o_stat,
    output sitoda_pkg::t_digit [sitoda_pkg::NUM_DIGITS-1:0]      o_digits
);

    logic [sitoda_pkg::BIN_W-1:0]                   r_bin, n_bin;
    sitoda_pkg::t_digit [sitoda_pkg::NUM_DIGITS-1:0] r_bcd, n_bcd, adj;
    logic [sitoda_pkg::CNT_W-1:0]                   r_cnt;
    logic                                           r_busy;
    logic                                           r_done;
    logic [sitoda_pkg::DIG_IDX_W-1:0]               ndig;

    // one shift-add-3 step per cycle while busy
    always_comb begin
        for (int i = 0; i < sitoda_pkg::NUM_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= sitoda_pkg::BCD_ADJ_LIM) ? r_bcd[i] + sitoda_pkg::BCD_ADJ
                                                           : r_bcd[i];
        end
        n_bcd[0] = {adj[0][2:0], r_bin[sitoda_pkg::BIN_W-1]};
        for (int i = 1; i < sitoda_pkg::NUM_DIGITS; i++) begin
            n_bcd[i] = {adj[i][2:0], adj[i-1][3]};
        end
        n_bin = {r_bin[sitoda_pkg::BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sitoda_pkg::LAST_SHIFT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bin <= i_cmd.mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    // count of significant digits, at least one
    always_comb begin
        ndig = sitoda_pkg::DIG_IDX_W'(1);
        for (int i = 1; i < sitoda_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[i] != '0) begin
                ndig = sitoda_pkg::DIG_IDX_W'(i + 1);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.ndig = ndig;
    assign o_digits    = r_bcd;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Channel   | Dir | Word                                   | Per number
// s_axis    | in  | tdata[31:0] number (signed)            | 1 word
// m_axis    | out | tdata[5:0] character, [7:6] zero;      | 1 to 11 words
//           |     | tlast = last character                 |
//
// Each number is accepted, run through 32 shift-add-3 steps in the BCD unit,
// digit-counted, then sent at one character per cycle while m_axis is ready.
// The shared BCD shift register sets the conversion time.
// s_axis_tready is high only while no number is in flight; the last character
// may still wait in the output register while the next number is taken.
// m_axis stalls hold the emitter. Reset is synchronous, active low.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic        m_axis_tlast    // last
);

    sitoda_pkg::t_state                                   r_state, n_state;
    sitoda_pkg::t_bcd_cmd                                 bcd_cmd;
    sitoda_pkg::t_bcd_stat                                bcd_stat;
    sitoda_pkg::t_digit [sitoda_pkg::NUM_DIGITS-1:0]      digits;

    logic                                 r_neg, n_neg;
    logic [sitoda_pkg::DIG_IDX_W-1:0]     r_idx, n_idx;
    logic                                 r_ovalid, n_ovalid;
    logic [sitoda_pkg::CHAR_W-1:0]        r_char, n_char;
    logic                                 r_last, n_last;
    logic                                 in_acc;
    logic                                 ld;
    logic                                 char_is_minus;
    logic                                 char_is_digit;
    logic                                 char_ok;

    sitoda_bcd_unit u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (bcd_cmd),
        .o_stat   (bcd_stat),
        .o_digits (digits)
    );

    assign s_axis_tready = (r_state == sitoda_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign ld            = !r_ovalid || m_axis_tready;

    assign bcd_cmd.start = in_acc;
    assign bcd_cmd.mag   = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            sitoda_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_neg   = s_axis_tdata[31];
                    n_state = sitoda_pkg::ST_CONV;
                end
            end
            sitoda_pkg::ST_CONV: begin
                if (bcd_stat.done) begin
                    n_idx   = bcd_stat.ndig - 1'b1;
                    n_state = sitoda_pkg::ST_EMIT;
                end
            end
            sitoda_pkg::ST_EMIT: begin
                if (ld) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        // sign goes out ahead of the digits
                        n_char = sitoda_pkg::ASCII_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = sitoda_pkg::ASCII_ZERO | {2'b00, digits[r_idx]};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = sitoda_pkg::ST_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = sitoda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sitoda_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_char};
    assign m_axis_tlast  = r_last;

    assign char_is_minus = (r_char == sitoda_pkg::ASCII_MINUS);
    assign char_is_digit = (r_char >= sitoda_pkg::ASCII_ZERO)
                        && (r_char <= (sitoda_pkg::ASCII_ZERO + 6'd9));
    assign char_ok       = char_is_minus || char_is_digit;

    `ASSERT_CLK(a_ready_unit_idle, s_axis_tready |-> !bcd_stat.busy, "ready while BCD unit busy")
    `ASSERT_CLK(a_char_legal, m_axis_tvalid |-> char_ok, "illegal character word")
    `ASSERT_CLK(a_minus_not_last, (m_axis_tvalid && char_is_minus) |-> !m_axis_tlast, "minus last")
    `ASSERT_CLK_ALWAYS(a_reset_idle, !i_rst_n |=> (s_axis_tready && !r_ovalid), "not idle")

endmodule

// ----- verif/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;

    localparam logic [sitoda_pkg::CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [sitoda_pkg::CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam int NUM_RANDOM  = 238;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [sitoda_pkg::CHAR_W-1:0] ch;
        logic                          last;
    } t_char_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] number
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [5:0] character, [7:6] zero
    logic m_axis_tlast;               // last

    logic [sitoda_pkg::BIN_W-1:0] pending_numbers[$];
    t_char_word                   expected_text[$];
    int n_total = 0;
    int n_sent = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int hold_cnt = 0;
    logic hold_fired = 1'b0;

    signed_int_to_decimal_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Decimal text of one number, sign first, most significant digit next.
    task automatic predict_text(input logic [sitoda_pkg::BIN_W-1:0] num);
        logic [32:0] mag;
        logic [3:0]  dig [0:9];
        int nd;
        nd = 0;
        mag = num[31] ? (33'h1_0000_0000 - {1'b0, num}) : {1'b0, num};
        do begin
            dig[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end while (mag != 0 && nd < 10);
        if (num[31]) begin
            expected_text.push_back('{CH_MINUS, 1'b0});
        end
        for (int k = nd - 1; k >= 0; k--) begin
            expected_text.push_back('{CH_ZERO + sitoda_pkg::CHAR_W'(dig[k]), k == 0});
        end
    endtask

    task automatic flag_error(input string msg);
        if (n_errors < MAX_REPORTS) begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    // Mix of full-range words, short numbers, random-length numbers and values around powers of ten.
    function automatic logic [sitoda_pkg::BIN_W-1:0] random_number();
        longint unsigned span;
        longint unsigned mag;
        int kind;
        span = 1;
        kind = $urandom_range(0, 3);
        repeat ($urandom_range(1, 10)) span = span * 10;
        case (kind)
            0: return $urandom();
            1: mag = $urandom_range(0, 99);
            2: mag = {$urandom(), $urandom()} % span;
            default: mag = span + $urandom_range(0, 4) - 2;
        endcase
        if ($urandom_range(0, 1)) begin
            if (mag > 64'h8000_0000) mag = mag % 64'h8000_0001;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = mag % 64'h8000_0000;
        return 32'(mag);
    endfunction

    // idle percentages: sender-heavy phase, receiver-heavy phase, then none
    function automatic int tx_idle_pct(input int sent);
        if (sent < n_total / 3) return 36;
        if (sent < 2 * n_total / 3) return 45;
        return 0;
    endfunction

    function automatic int rx_idle_pct(input int sent);
        if (sent < n_total / 3) return 45;
        if (sent < 2 * n_total / 3) return 36;
        return 0;
    endfunction

    // Sender: holds a word until taken, predicts its text on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_text(s_axis_tdata);
            end
            if (pending_numbers.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct(n_sent)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_numbers.pop_front();
                n_sent        <= n_sent + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off early in the no-idle phase; the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt   <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && n_total > 0 && n_sent >= 2 * n_total / 3 + 5) begin
            hold_cnt   <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle_pct(n_sent));
        end
    end

    always @(posedge i_clk) begin : monitor
        t_char_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_text.size() == 0) begin
                flag_error($sformatf("unexpected word data=%0d last=%0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                want = expected_text.pop_front();
                if (m_axis_tdata !== {2'b00, want.ch} || m_axis_tlast !== want.last) begin
                    flag_error($sformatf("data exp %0d got %0d, last exp %0b got %0b",
                                         {2'b00, want.ch}, m_axis_tdata,
                                         want.last, m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("[signed_int_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    initial begin
        // extremes, zero, sign, digit-count boundaries, bit patterns
        pending_numbers = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10,
                            32'd99, 32'd100, 32'd999999999, 32'd1000000000,
                            -32'sd999999999, -32'sd1000000000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
                            32'd1234567890, -32'sd1234567890};
        for (int i = 0; i < NUM_RANDOM; i++) begin
            pending_numbers.push_back(random_number());
        end
        n_total = pending_numbers.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || s_axis_tvalid || expected_text.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN) @(negedge i_clk);
        if (expected_text.size() != 0) begin
            flag_error($sformatf("%0d characters never arrived", expected_text.size()));
        end

        if (n_errors == 0) begin
            $display("[signed_int_to_decimal_ascii] OK");
        end else begin
            $display("[signed_int_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule
